@@ src/pidc_pkg.sv @@
// Shared types, control codes and saturation helper for the PID controller.
package pidc_pkg;

    // Configuration register indexes
    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SETPOINT     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_MAX = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_MIN = 3'd5;
    localparam int unsigned ADDR_W = 5;

    // Datapath operations, one per microcode step
    localparam int unsigned OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP   = 4'd0;
    localparam logic [OP_W-1:0] OP_WAIT  = 4'd1;   // take a sample beat
    localparam logic [OP_W-1:0] OP_ERR   = 4'd2;   // error, elapsed ticks
    localparam logic [OP_W-1:0] OP_INT   = 4'd3;   // integral clamp, error delta
    localparam logic [OP_W-1:0] OP_MULT  = 4'd4;   // delta * ticks per second
    localparam logic [OP_W-1:0] OP_DIVGO = 4'd5;   // launch divider
    localparam logic [OP_W-1:0] OP_DERIV = 4'd6;   // derivative from quotient
    localparam logic [OP_W-1:0] OP_DZERO = 4'd7;   // derivative forced to zero
    localparam logic [OP_W-1:0] OP_MULP  = 4'd8;   // gain_p * error
    localparam logic [OP_W-1:0] OP_MULI  = 4'd9;   // gain_i * integral
    localparam logic [OP_W-1:0] OP_MULD  = 4'd10;  // gain_d * derivative
    localparam logic [OP_W-1:0] OP_ADDL  = 4'd11;  // fold last product
    localparam logic [OP_W-1:0] OP_OUT   = 4'd12;  // load result register

    // Operation handed from sequencer to datapath
    typedef struct packed {
        logic [OP_W-1:0] op;
    } ctl_t;

    // Status fed back to the sequencer's jump logic
    typedef struct packed {
        logic in_acc;
        logic out_free;
        logic el_zero;
        logic div_busy;
    } sts_t;

    // Configuration register file contents
    typedef struct packed {
        logic signed [31:0] gain_p;
        logic signed [31:0] gain_i;
        logic signed [31:0] gain_d;
        logic signed [31:0] setpoint;
        logic signed [31:0] integral_max;
        logic signed [31:0] integral_min;
    } cfg_t;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } sat_t;

    localparam logic signed [65:0] Q_MAX = 66'sd2147483647;
    localparam logic signed [65:0] Q_MIN = -66'sd2147483648;

    // Clip a wide signed value to the 32-bit range
    function automatic sat_t sat_q(input logic signed [65:0] v);
        sat_t r;
        if (v > Q_MAX)
        begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFF_FFFF;
        end
        else if (v < Q_MIN)
        begin
            r.clip = 1'b1;
            r.val  = 32'sh8000_0000;
        end
        else
        begin
            r.clip = 1'b0;
            r.val  = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ src/pidc_if.sv @@
// Valid/ready channel interfaces for samples in and drive results out.
interface pidc_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] measured;
    logic        [31:0] tick_ms;

    modport source (output valid, output measured, output tick_ms, input ready);
    modport sink   (input valid, input measured, input tick_ms, output ready);
endinterface

interface pidc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;
    logic               saturated;

    modport source (output valid, output drive, output saturated, input ready);
    modport sink   (input valid, input drive, input saturated, output ready);
endinterface

@@ src/pid_controller_clamped_integral_unit.sv @@
// PID controller top level: APB register file, sequencer and datapath.
//
// Usage:
//   sample channel takes one beat per control step: measured (signed Q16.16)
//   and tick_ms (free-running millisecond count). result channel returns one
//   beat per sample: drive (signed Q16.16) and saturated (clip flag).
//   Registers gain_p, gain_i, gain_d, setpoint, integral_max, integral_min
//   sit at byte addresses 0x00..0x14; write them only while no sample is
//   in flight.
// Operation:
//   One sample is processed at a time. With ticks elapsed, the derivative
//   goes through the bit-serial divider, whose dividend is NUM_W =
//   32 + clog2(TICKS_PER_SECOND + 1) bits wide. With no ticks elapsed the
//   divide is skipped.
// Reset clears the integral, previous error and previous tick, loads the
//   register defaults and drops result valid. A stalled result is held in
//   the output register; the next sample is still taken and processed, and
//   its result waits until the pending beat is taken.
module pid_controller_clamped_integral_unit #(
    parameter int unsigned TICKS_PER_SECOND = 1000
) (
    input  logic                        clk,
    input  logic                        rst_n,
    pidc_in_if.sink                     sample,
    pidc_out_if.source                  result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pidc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pidc_pkg::*;

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    ctl_t                 ctl;
    sts_t                 sts;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    // Register writes; unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p       <= '0;
            cfg_reg.gain_i       <= '0;
            cfg_reg.gain_d       <= '0;
            cfg_reg.setpoint     <= '0;
            cfg_reg.integral_max <= 32'sh7FFF_FFFF;
            cfg_reg.integral_min <= 32'sh8000_0000;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_GAIN_P:       cfg_reg.gain_p       <= pwdata;
                REG_GAIN_I:       cfg_reg.gain_i       <= pwdata;
                REG_GAIN_D:       cfg_reg.gain_d       <= pwdata;
                REG_SETPOINT:     cfg_reg.setpoint     <= pwdata;
                REG_INTEGRAL_MAX: cfg_reg.integral_max <= pwdata;
                REG_INTEGRAL_MIN: cfg_reg.integral_min <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (reg_idx)
            REG_GAIN_P:       prdata = cfg_reg.gain_p;
            REG_GAIN_I:       prdata = cfg_reg.gain_i;
            REG_GAIN_D:       prdata = cfg_reg.gain_d;
            REG_SETPOINT:     prdata = cfg_reg.setpoint;
            REG_INTEGRAL_MAX: prdata = cfg_reg.integral_max;
            REG_INTEGRAL_MIN: prdata = cfg_reg.integral_min;
            default:          prdata = '0;
        endcase
    end

    pidc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    pidc_dp #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .cfg    (cfg_reg),
        .sts    (sts),
        .sample (sample),
        .result (result)
    );

endmodule

@@ src/pidc_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module pidc_div #(
    parameter int unsigned NUM_W = 42
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [31:0]      den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [31:0]      rem_reg;
    logic [31:0]      rem_next;
    logic [NUM_W-1:0] dvd_reg;
    logic [NUM_W-1:0] dvd_next;
    logic [31:0]      den_reg;
    logic [32:0]      trial;
    logic             qbit;

    // Shift in next dividend bit and trial subtract
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[NUM_W-1]};
        qbit     = (trial >= {1'b0, den_reg});
        rem_next = qbit ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
        dvd_next = {dvd_reg[NUM_W-2:0], qbit};
        cnt_next = cnt_reg - CNT_W'(1);
    end

    // Iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= CNT_W'(NUM_W);
        else if (busy)
            cnt_reg <= cnt_next;
    end

    // Remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= num;
            den_reg <= den;
        end
        else if (busy)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quo  = dvd_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n) start |=> busy)
        else $error("divider not busy after start");

endmodule

@@ src/pidc_seq.sv @@
// Microcode sequencer: program ROM, step counter and conditional jumps.
module pidc_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  pidc_pkg::sts_t sts,
    output pidc_pkg::ctl_t ctl
);
    import pidc_pkg::*;

    localparam int unsigned PC_W = 4;
    localparam int unsigned ROM_DEPTH = 1 << PC_W;

    // Jump conditions: jump to target when true, else step on
    localparam logic [2:0] C_NEXT     = 3'd0;
    localparam logic [2:0] C_ALWAYS   = 3'd1;
    localparam logic [2:0] C_NO_IN    = 3'd2;
    localparam logic [2:0] C_OUT_FULL = 3'd3;
    localparam logic [2:0] C_EL_ZERO  = 3'd4;
    localparam logic [2:0] C_DIV_BUSY = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } uword_t;

    // Control store
    localparam uword_t ROM [ROM_DEPTH] = '{
        '{OP_WAIT,  C_NO_IN,    4'd0},   // 0: wait for a sample
        '{OP_ERR,   C_NEXT,     4'd0},   // 1
        '{OP_INT,   C_NEXT,     4'd0},   // 2
        '{OP_MULT,  C_EL_ZERO,  4'd7},   // 3: skip divide if no ticks passed
        '{OP_DIVGO, C_NEXT,     4'd0},   // 4
        '{OP_NOP,   C_DIV_BUSY, 4'd5},   // 5: spin on divider
        '{OP_DERIV, C_ALWAYS,   4'd8},   // 6
        '{OP_DZERO, C_NEXT,     4'd0},   // 7
        '{OP_MULP,  C_NEXT,     4'd0},   // 8
        '{OP_MULI,  C_NEXT,     4'd0},   // 9
        '{OP_MULD,  C_NEXT,     4'd0},   // 10
        '{OP_ADDL,  C_NEXT,     4'd0},   // 11
        '{OP_OUT,   C_OUT_FULL, 4'd12},  // 12: hold until result slot frees
        '{OP_NOP,   C_ALWAYS,   4'd0},   // 13
        '{OP_NOP,   C_ALWAYS,   4'd0},
        '{OP_NOP,   C_ALWAYS,   4'd0}
    };

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          uw;
    logic            take;

    // Next step selection
    always_comb
    begin
        uw = ROM[pc_reg];
        unique case (uw.cond)
            C_NEXT:     take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_IN:    take = !sts.in_acc;
            C_OUT_FULL: take = !sts.out_free;
            C_EL_ZERO:  take = sts.el_zero;
            C_DIV_BUSY: take = sts.div_busy;
            default:    take = 1'b1;
        endcase
        pc_next = take ? uw.target : pc_reg + PC_W'(1);
        ctl.op  = uw.op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= '0;
        else
            pc_reg <= pc_next;
    end

endmodule

@@ src/pidc_dp.sv @@
// PID datapath: working registers, shared multiplier, divider, result register.
module pidc_dp #(
    parameter int unsigned TICKS_PER_SECOND = 1000
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pidc_pkg::ctl_t ctl,
    input  pidc_pkg::cfg_t cfg,
    output pidc_pkg::sts_t sts,
    pidc_in_if.sink        sample,
    pidc_out_if.source     result
);
    import pidc_pkg::*;

    localparam int unsigned TPS_W = $clog2(TICKS_PER_SECOND + 1);
    localparam int unsigned NUM_W = 32 + TPS_W;
    localparam logic signed [32:0] TPS_S = 33'(TICKS_PER_SECOND);

    // Control-state registers
    logic signed [31:0] acc_reg;
    logic signed [31:0] perr_reg;
    logic        [31:0] ptick_reg;
    logic               out_valid_reg;

    // Working registers
    logic signed [31:0] meas_reg;
    logic        [31:0] tick_reg;
    logic signed [31:0] err_reg;
    logic        [31:0] el_reg;
    logic signed [32:0] diff_reg;
    logic signed [31:0] deriv_reg;
    logic signed [65:0] prod_reg;
    logic signed [65:0] total_reg;
    logic               clip_reg;
    logic signed [31:0] drive_reg;
    logic               sat_reg;

    logic signed [32:0] err_diff;
    sat_t               err_sat;
    logic signed [32:0] int_sum;
    logic signed [31:0] acc_next;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [65:0] prod_abs;
    logic signed [NUM_W:0] q_mag;
    logic signed [NUM_W:0] q_sgn;
    sat_t               deriv_sat;
    sat_t               drive_sat;
    logic               in_acc;
    logic               out_free;
    logic               div_start;
    logic               div_busy;
    logic [NUM_W-1:0]   div_quo;

    // Handshake decode
    assign in_acc   = (ctl.op == OP_WAIT) && sample.valid;
    assign out_free = !out_valid_reg || result.ready;
    assign div_start = (ctl.op == OP_DIVGO);

    assign sample.ready     = (ctl.op == OP_WAIT);
    assign result.valid     = out_valid_reg;
    assign result.drive     = drive_reg;
    assign result.saturated = sat_reg;

    assign sts.in_acc   = in_acc;
    assign sts.out_free = out_free;
    assign sts.el_zero  = (el_reg == '0);
    assign sts.div_busy = div_busy;

    // Error, integral clamp, derivative and drive saturation
    always_comb
    begin
        err_diff = 33'(cfg.setpoint) - 33'(meas_reg);
        err_sat  = sat_q(66'(err_diff));
        int_sum  = 33'(acc_reg) + 33'(err_reg);
        if (int_sum > 33'(cfg.integral_max))
            acc_next = cfg.integral_max;
        else if (int_sum < 33'(cfg.integral_min))
            acc_next = cfg.integral_min;
        else
            acc_next = int_sum[31:0];
        prod_abs  = prod_reg[65] ? -prod_reg : prod_reg;
        q_mag     = $signed({1'b0, div_quo});
        q_sgn     = prod_reg[65] ? -q_mag : q_mag;
        deriv_sat = sat_q(66'(q_sgn));
        drive_sat = sat_q(total_reg >>> 16);
    end

    // Shared multiplier operand select
    always_comb
    begin
        unique case (ctl.op)
            OP_MULT:
            begin
                mul_a = diff_reg;
                mul_b = TPS_S;
            end
            OP_MULP:
            begin
                mul_a = 33'(cfg.gain_p);
                mul_b = 33'(err_reg);
            end
            OP_MULI:
            begin
                mul_a = 33'(cfg.gain_i);
                mul_b = 33'(acc_reg);
            end
            OP_MULD:
            begin
                mul_a = 33'(cfg.gain_d);
                mul_b = 33'(deriv_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    pidc_div #(.NUM_W(NUM_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_abs[NUM_W-1:0]),
        .den   (el_reg),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    // Controller state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            perr_reg      <= '0;
            ptick_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.op == OP_INT)
            begin
                acc_reg   <= acc_next;
                perr_reg  <= err_reg;
                ptick_reg <= tick_reg;
            end
            if (ctl.op == OP_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers, one operation per step
    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            OP_WAIT:
            begin
                if (sample.valid)
                begin
                    meas_reg <= sample.measured;
                    tick_reg <= sample.tick_ms;
                end
            end
            OP_ERR:
            begin
                err_reg  <= err_sat.val;
                clip_reg <= err_sat.clip;
                el_reg   <= tick_reg - ptick_reg;
            end
            OP_INT:
                diff_reg <= 33'(err_reg) - 33'(perr_reg);
            OP_MULT:
                prod_reg <= mul_p;
            OP_DERIV:
            begin
                deriv_reg <= deriv_sat.val;
                clip_reg  <= clip_reg | deriv_sat.clip;
            end
            OP_DZERO:
                deriv_reg <= '0;
            OP_MULP:
            begin
                prod_reg  <= mul_p;
                total_reg <= '0;
            end
            OP_MULI, OP_MULD:
            begin
                prod_reg  <= mul_p;
                total_reg <= total_reg + prod_reg;
            end
            OP_ADDL:
                total_reg <= total_reg + prod_reg;
            OP_OUT:
            begin
                if (out_free)
                begin
                    drive_reg <= drive_sat.val;
                    sat_reg   <= clip_reg | drive_sat.clip;
                end
            end
            default:
            begin
            end
        endcase
    end

    a_int_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_INT && cfg.integral_min <= cfg.integral_max)
        |=> (acc_reg <= cfg.integral_max && acc_reg >= cfg.integral_min))
        else $error("integral outside clamp limits");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> ($stable(drive_reg) && $stable(sat_reg)))
        else $error("pending result overwritten");

    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        sample.ready |-> !div_busy)
        else $error("divider busy while taking a sample");

endmodule
